// ----- hdl/lcps_pkg.sv -----
package lcps_pkg;

    localparam int MAX_LEDS_DEF = 8;

    localparam logic [3:0]  LED_COUNT_RST  = 4'd6;
    localparam logic [15:0] STEP_DELAY_RST = 16'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_EFFECT = 2'd0;
    localparam logic [1:0] CFG_IDX_COUNT  = 2'd1;
    localparam logic [1:0] CFG_IDX_DELAY  = 2'd2;

    typedef enum logic [2:0] {
        FX_SWEEP_UP   = 3'd0,
        FX_SWEEP_DOWN = 3'd1,
        FX_BOUNCE     = 3'd2,
        FX_PAIRS_OUT  = 3'd3,
        FX_PAIRS_IN   = 3'd4
    } effect_t;

    typedef struct packed {
        effect_t     effect_mode;
        logic [3:0]  led_count;
        logic [15:0] step_delay;
    } lcps_cfg_t;

    typedef struct packed {
        logic [7:0]  pattern;
        logic [3:0]  outer;
        logic [3:0]  inner;
        logic        bounce;
        logic [15:0] hold;
        logic        active;
    } lcps_state_t;

    typedef struct packed {
        logic [7:0] led_pattern;
        logic       running;
        logic       done_res;
    } lcps_result_t;

endpackage

// ----- hdl/lcps_cfg_regs.sv -----
module lcps_cfg_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output lcps_pkg::lcps_cfg_t  cfg
);

    lcps_pkg::lcps_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.effect_mode <= lcps_pkg::FX_SWEEP_UP;
            cfg_reg.led_count   <= lcps_pkg::LED_COUNT_RST;
            cfg_reg.step_delay  <= lcps_pkg::STEP_DELAY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lcps_pkg::CFG_IDX_EFFECT: begin
                    cfg_reg.effect_mode <= lcps_pkg::effect_t'(cfg_data[2:0]);
                end
                lcps_pkg::CFG_IDX_COUNT: begin
                    cfg_reg.led_count <= cfg_data[3:0];
                end
                lcps_pkg::CFG_IDX_DELAY: begin
                    cfg_reg.step_delay <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hdl/lcps_frame_engine.sv -----
module lcps_frame_engine #(
    parameter int MAX_LEDS = lcps_pkg::MAX_LEDS_DEF
) (
    input  lcps_pkg::lcps_cfg_t    cfg,
    input  logic                   start,
    input  lcps_pkg::lcps_state_t  cur,
    output lcps_pkg::lcps_state_t  nxt,
    output lcps_pkg::lcps_result_t res
);

    localparam logic [3:0] MAX_N = 4'(MAX_LEDS);

    function automatic logic [7:0] led_bit(input logic [3:0] p);
        logic [7:0] b;
        b = 8'd0;
        if (p < MAX_N) b = 8'd1 << p[2:0];
        return b;
    endfunction

    function automatic logic [7:0] led_pair(input logic [3:0] p, input logic [3:0] n);
        logic [7:0] b;
        b = 8'd0;
        if (p < n) b = led_bit(p) | led_bit(n - 4'd1 - p);
        return b;
    endfunction

    function automatic logic [7:0] frame(input lcps_pkg::lcps_state_t st,
                                         input lcps_pkg::effect_t mode,
                                         input logic [3:0] n);
        logic [7:0] f;
        case (mode)
            lcps_pkg::FX_SWEEP_UP,
            lcps_pkg::FX_SWEEP_DOWN: f = st.pattern | led_bit(st.inner);
            lcps_pkg::FX_BOUNCE:     f = led_bit(st.inner);
            lcps_pkg::FX_PAIRS_OUT,
            lcps_pkg::FX_PAIRS_IN:   f = st.pattern | led_pair(st.inner, n);
            default:                 f = st.pattern;
        endcase
        return f;
    endfunction

    logic [3:0]            n_live;
    logic [3:0]            h_live;
    logic [15:0]           delay;
    lcps_pkg::effect_t     mode;
    lcps_pkg::lcps_state_t pre;
    lcps_pkg::lcps_state_t settled;
    logic                  begin_fail;
    logic                  set_ok;

    assign mode   = cfg.effect_mode;
    assign n_live = (cfg.led_count > MAX_N) ? MAX_N : cfg.led_count;
    assign h_live = {1'b0, n_live[3:1]};
    assign delay  = (cfg.step_delay == 16'd0) ? 16'd1 : cfg.step_delay;

    // candidate position: fresh effect on start, next inner step otherwise
    always_comb begin
        pre        = cur;
        begin_fail = 1'b0;
        if (start) begin
            pre.pattern = 8'd0;
            pre.bounce  = 1'b0;
            pre.outer   = 4'd0;
            pre.inner   = 4'd0;
            if (mode == lcps_pkg::FX_SWEEP_DOWN) begin
                if (n_live == 4'd0) begin_fail = 1'b1;
                else pre.outer = n_live - 4'd1;
            end
            if (mode == lcps_pkg::FX_PAIRS_IN) begin
                if (h_live == 4'd0) begin_fail = 1'b1;
                else pre.outer = h_live - 4'd1;
            end
        end else begin
            pre.inner = cur.inner + 4'd1;
        end
    end

    // walk to the next valid frame; each effect needs at most two latch steps
    always_comb begin
        settled = pre;
        set_ok  = 1'b0;
        case (mode)
            lcps_pkg::FX_SWEEP_UP: begin
                if (pre.outer >= n_live) begin
                    set_ok = 1'b0;
                end else if (pre.inner < n_live) begin
                    set_ok = 1'b1;
                end else begin
                    settled.pattern = pre.pattern | led_bit(pre.outer);
                    settled.outer   = pre.outer + 4'd1;
                    settled.inner   = pre.outer + 4'd1;
                    set_ok          = (settled.outer < n_live);
                end
            end
            lcps_pkg::FX_SWEEP_DOWN: begin
                if (pre.inner < pre.outer) begin
                    set_ok = 1'b1;
                end else begin
                    settled.pattern = pre.pattern | led_bit(pre.outer);
                    if (pre.outer != 4'd0) begin
                        settled.outer = pre.outer - 4'd1;
                        settled.inner = 4'd0;
                        if (settled.outer != 4'd0) begin
                            set_ok = 1'b1;
                        end else begin
                            settled.pattern = settled.pattern | led_bit(4'd0);
                        end
                    end
                end
            end
            lcps_pkg::FX_BOUNCE: begin
                if (pre.bounce || (pre.inner < n_live)) begin
                    set_ok = 1'b1;
                end else if (n_live != 4'd0) begin
                    settled.bounce = 1'b1;
                    settled.inner  = n_live - 4'd1;
                    set_ok         = 1'b1;
                end
            end
            lcps_pkg::FX_PAIRS_OUT: begin
                if (pre.outer >= h_live) begin
                    set_ok = 1'b0;
                end else if (pre.inner < h_live) begin
                    set_ok = 1'b1;
                end else begin
                    settled.pattern = pre.pattern | led_pair(pre.outer, n_live);
                    settled.outer   = pre.outer + 4'd1;
                    settled.inner   = pre.outer + 4'd1;
                    set_ok          = (settled.outer < h_live);
                end
            end
            lcps_pkg::FX_PAIRS_IN: begin
                if (pre.inner <= pre.outer) begin
                    set_ok = 1'b1;
                end else begin
                    settled.pattern = pre.pattern | led_pair(pre.outer, n_live);
                    if (pre.outer != 4'd0) begin
                        settled.outer = pre.outer - 4'd1;
                        settled.inner = 4'd0;
                        set_ok        = 1'b1;
                    end
                end
            end
            default: begin
                set_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic step;
        logic have;
        nxt  = cur;
        res  = '0;
        step = 1'b0;
        have = 1'b0;
        if (start) begin
            nxt        = begin_fail ? pre : settled;
            nxt.active = 1'b1;
            have       = !begin_fail && set_ok;
            step       = 1'b1;
        end else if (cur.active) begin
            if (cur.hold < delay) begin
                nxt.hold        = cur.hold + 16'd1;
                res.led_pattern = frame(cur, mode, n_live);
                res.running     = 1'b1;
            end else begin
                step = 1'b1;
                if (mode == lcps_pkg::FX_BOUNCE && cur.bounce) begin
                    if (cur.inner != 4'd0) begin
                        nxt.inner = cur.inner - 4'd1;
                        have      = 1'b1;
                    end
                end else begin
                    nxt  = settled;
                    have = set_ok;
                end
            end
        end else begin
            res.led_pattern = cur.pattern;
        end

        if (step) begin
            if (have) begin
                nxt.hold        = 16'd1;
                res.led_pattern = frame(nxt, mode, n_live);
                res.running     = 1'b1;
            end else begin
                nxt.active      = 1'b0;
                nxt.hold        = 16'd0;
                res.led_pattern = nxt.pattern;
                res.done_res    = 1'b1;
            end
        end
    end

endmodule

// ----- hdl/led_chase_pattern_sequencer.sv -----
// LED chase pattern sequencer. Every input transfer is one time tick and yields
// exactly one result transfer carrying the LED bar byte, a running flag (tuser)
// and a done flag (tlast, set on the tick where the settled final pattern
// appears). A tick with start_req set clears the bar and restarts the effect
// chosen by effect_mode; each frame is held for step_delay ticks. One tick is
// taken per clock unless the result channel stalls; a tick passes the input
// register, then the frame logic feeds the result register and effect state
// at the same edge. Throughput is set by the state update loop. The user must
// write cfg (index 0 effect_mode, 1 led_count, 2 step_delay) only while no
// tick is in flight; the block does not enforce it. Values apply from next tick.
module led_chase_pattern_sequencer #(
    parameter int MAX_LEDS = lcps_pkg::MAX_LEDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] start_req, [7:1] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] led_pattern
    output logic        m_tuser,    // [0] running
    output logic        m_tlast,    // done_res

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lcps_pkg::lcps_cfg_t    cfg;
    lcps_pkg::lcps_state_t  state_reg;
    lcps_pkg::lcps_state_t  state_next;
    lcps_pkg::lcps_result_t res_next;
    lcps_pkg::lcps_result_t res_reg;

    logic s1_valid_reg;
    logic s1_start_reg;
    logic m_valid_reg;
    logic out_ready;
    logic fire;

    lcps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcps_frame_engine #(
        .MAX_LEDS (MAX_LEDS)
    ) u_engine (
        .cfg   (cfg),
        .start (s1_start_reg),
        .cur   (state_reg),
        .nxt   (state_next),
        .res   (res_next)
    );

    // result register frees up when empty or being drained this cycle
    assign out_ready = !m_valid_reg || m_tready;
    assign fire      = s1_valid_reg && out_ready;
    assign s_tready  = !s1_valid_reg || out_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            s1_valid_reg <= 1'b1;
        end else if (fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_start_reg <= s_tdata[0];
        end
    end

    // effect state advances only when the tick's result is captured
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg.led_pattern;
    assign m_tuser  = res_reg.running;
    assign m_tlast  = res_reg.done_res;

    // a running effect always has a frame on display
    a_active_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.active |-> (state_reg.hold != 16'd0))
        else $error("active effect with zero hold count");

    // the settled pattern is never reported while still running
    a_done_not_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tlast && m_tuser))
        else $error("done and running set together");

    // LEDs beyond the supported bar are never driven
    a_unused_leds_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >> MAX_LEDS) == 8'd0))
        else $error("LED bit above MAX_LEDS driven");

    // state only moves on a captured tick
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(state_reg))
        else $error("effect state changed without a tick");

endmodule
